@@ rtl/id3v2_frame_stream_parser_macros.svh @@
// ----------------------------------------------------------------------------
// ID3v2 frame stream parser assertion macros
// Shared concurrent assertion forms for the parser checkers.
// ----------------------------------------------------------------------------
`ifndef ID3V2_FRAME_STREAM_PARSER_MACROS_SVH
`define ID3V2_FRAME_STREAM_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ID3FSP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ID3FSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/id3fsp_pkg.sv @@
// ----------------------------------------------------------------------------
// ID3v2 frame stream parser package
// Request types, result codes and the table of known frame IDs.
// ----------------------------------------------------------------------------
`default_nettype none

package id3fsp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_file;
  } byte_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] tag_code;
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic       error_code;
  } result_req_t;

  localparam logic [1:0] KIND_FRAME_START = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD     = 2'd1;
  localparam logic [1:0] KIND_ERROR       = 2'd2;
  localparam logic [1:0] KIND_DONE        = 2'd3;

  localparam logic ERR_UNKNOWN_ID = 1'b0;
  localparam logic ERR_ZERO_SIZE  = 1'b1;

  localparam logic [3:0] HEADER_BYTES = 4'd10;
  localparam logic [3:0] ID_BYTES     = 4'd4;
  localparam logic [3:0] SIZE_BYTES   = 4'd4;
  localparam logic [3:0] SKIP_BYTES   = 4'd3;

  localparam int NUM_TAGS = 9;

  localparam logic [31:0] KNOWN_IDS [NUM_TAGS] = '{
    32'h5449_5432,  // TIT2
    32'h5441_4C42,  // TALB
    32'h5450_4531,  // TPE1
    32'h5459_4552,  // TYER
    32'h5443_4F4E,  // TCON
    32'h434F_4D4D,  // COMM
    32'h4950_4C53,  // IPLS
    32'h5443_4F50,  // TCOP
    32'h5443_4F4D   // TCOM
  };

  typedef struct packed {
    logic       hit;
    logic [3:0] code;
  } tag_match_t;

  function automatic tag_match_t match_tag(input logic [31:0] id);
    tag_match_t m;
    m.hit  = 1'b0;
    m.code = 4'd0;
    for (int k = NUM_TAGS - 1; k >= 0; k--) begin
      if (KNOWN_IDS[k] == id) begin
        m.hit  = 1'b1;
        m.code = 4'(k);
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/id3v2_frame_stream_parser.sv @@
// ----------------------------------------------------------------------------
// ID3v2 frame stream parser
// Skips the tag header and splits the following frames into start, payload,
// error and done results.
// ----------------------------------------------------------------------------
// Each accepted byte request updates the parser state and the result
// register at the accepting clock edge, and any result appears on the output
// in the cycle after that accepting edge. A new byte is accepted in
// every cycle; byte_stall rises only while a finished result sits in the
// output register and result_stall holds it there. After an error or after
// the done report, bytes are consumed without results until a byte carrying
// new_file arrives. frames_to_read is loaded by cfg_write with cfg_wdata.
`default_nettype none

module id3v2_frame_stream_parser #(
  parameter int FramesToReadReset = 6
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      cfg_write,
  input  wire  [7:0]               cfg_wdata,
  input  wire                      byte_valid,
  output logic                     byte_stall,
  input  id3fsp_pkg::byte_req_t    byte_item,
  output logic                     result_valid,
  input  wire                      result_stall,
  output id3fsp_pkg::result_req_t  result_item
);
  import id3fsp_pkg::*;

  typedef enum logic [7:0] {
    PH_HEADER    = 8'b0000_0001,
    PH_ID        = 8'b0000_0010,
    PH_SIZE      = 8'b0000_0100,
    PH_SKIP      = 8'b0000_1000,
    PH_PAYLOAD   = 8'b0001_0000,
    PH_DONE_PEND = 8'b0010_0000,
    PH_IDLE      = 8'b0100_0000,
    PH_ERROR     = 8'b1000_0000
  } phase_t;

  phase_t      phase, phase_next, phase_eff;
  logic [3:0]  byte_count, byte_count_next, byte_count_eff, byte_count_inc;
  logic [31:0] id_shift, id_shift_next, id_shift_eff;
  logic [27:0] size_shift, size_shift_next, size_shift_eff;
  logic [27:0] length_left, length_left_next, length_left_eff, length_left_dec;
  logic [3:0]  current_tag, current_tag_next, current_tag_eff;
  logic [7:0]  frames_done, frames_done_next, frames_done_eff, frames_done_inc;
  logic [7:0]  frames_to_read;

  logic        accept;
  logic        has_result;
  result_req_t result_next;
  tag_match_t  tag_hit;

  assign byte_stall = result_valid & result_stall;
  assign accept     = byte_valid & ~byte_stall;

  assign phase_eff       = byte_item.new_file ? PH_HEADER : phase;
  assign byte_count_eff  = byte_item.new_file ? 4'd0 : byte_count;
  assign id_shift_eff    = byte_item.new_file ? 32'd0 : id_shift;
  assign size_shift_eff  = byte_item.new_file ? 28'd0 : size_shift;
  assign length_left_eff = byte_item.new_file ? 28'd0 : length_left;
  assign current_tag_eff = byte_item.new_file ? 4'd0 : current_tag;
  assign frames_done_eff = byte_item.new_file ? 8'd0 : frames_done;

  assign byte_count_inc  = byte_count_eff + 4'd1;
  assign frames_done_inc = frames_done_eff + 8'd1;
  assign length_left_dec = (length_left_eff != 28'd0) ? length_left_eff - 28'd1
                                                      : length_left_eff;
  assign tag_hit = match_tag({id_shift_eff[23:0], byte_item.data_byte});

  always_comb begin
    phase_next       = phase_eff;
    byte_count_next  = byte_count_eff;
    id_shift_next    = id_shift_eff;
    size_shift_next  = size_shift_eff;
    length_left_next = length_left_eff;
    current_tag_next = current_tag_eff;
    frames_done_next = frames_done_eff;
    has_result       = 1'b0;
    result_next      = '0;
    case (phase_eff)
      PH_HEADER: begin
        byte_count_next = byte_count_inc;
        if (byte_count_inc >= HEADER_BYTES) begin
          byte_count_next = 4'd0;
          phase_next = (frames_done_eff >= frames_to_read) ? PH_DONE_PEND : PH_ID;
        end
      end
      PH_ID: begin
        id_shift_next   = {id_shift_eff[23:0], byte_item.data_byte};
        byte_count_next = byte_count_inc;
        if (byte_count_inc >= ID_BYTES) begin
          byte_count_next = 4'd0;
          has_result      = 1'b1;
          if (tag_hit.hit) begin
            current_tag_next     = tag_hit.code;
            result_next.kind     = KIND_FRAME_START;
            result_next.tag_code = tag_hit.code;
            phase_next           = PH_SIZE;
          end else begin
            result_next.kind       = KIND_ERROR;
            result_next.error_code = ERR_UNKNOWN_ID;
            phase_next             = PH_ERROR;
          end
        end
      end
      PH_SIZE: begin
        size_shift_next = {size_shift_eff[20:0], byte_item.data_byte[6:0]};
        byte_count_next = byte_count_inc;
        if (byte_count_inc >= SIZE_BYTES) begin
          byte_count_next = 4'd0;
          if (size_shift_next == 28'd0) begin
            has_result             = 1'b1;
            result_next.kind       = KIND_ERROR;
            result_next.error_code = ERR_ZERO_SIZE;
            phase_next             = PH_ERROR;
          end else begin
            length_left_next = size_shift_next - 28'd1;
            phase_next       = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        byte_count_next = byte_count_inc;
        if (byte_count_inc >= SKIP_BYTES) begin
          byte_count_next = 4'd0;
          if (length_left_eff == 28'd0) begin
            frames_done_next = frames_done_inc;
            phase_next = (frames_done_inc >= frames_to_read) ? PH_DONE_PEND : PH_ID;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        has_result               = 1'b1;
        result_next.kind         = KIND_PAYLOAD;
        result_next.tag_code     = current_tag_eff;
        result_next.payload_byte = byte_item.data_byte;
        length_left_next         = length_left_dec;
        if (length_left_dec == 28'd0) begin
          result_next.last_of_frame = 1'b1;
          frames_done_next = frames_done_inc;
          phase_next = (frames_done_inc >= frames_to_read) ? PH_DONE_PEND : PH_ID;
        end
      end
      PH_DONE_PEND: begin
        has_result       = 1'b1;
        result_next.kind = KIND_DONE;
        phase_next       = PH_IDLE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      byte_count     <= 4'd0;
      current_tag    <= 4'd0;
      frames_done    <= 8'd0;
      frames_to_read <= 8'(FramesToReadReset);
      result_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        frames_to_read <= cfg_wdata;
      end
      if (accept) begin
        phase        <= phase_next;
        byte_count   <= byte_count_next;
        current_tag  <= current_tag_next;
        frames_done  <= frames_done_next;
        result_valid <= has_result;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id_shift    <= id_shift_next;
      size_shift  <= size_shift_next;
      length_left <= length_left_next;
      if (has_result) begin
        result_item <= result_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/id3fsp_checker.sv @@
// ----------------------------------------------------------------------------
// ID3v2 frame stream parser checker
// Port-level assertions on handshake behavior and result field encoding.
// ----------------------------------------------------------------------------
`default_nettype none

`include "id3v2_frame_stream_parser_macros.svh"

module id3fsp_checker (
  input wire                      clk,
  input wire                      rst,
  input wire                      byte_stall,
  input wire                      result_valid,
  input wire                      result_stall,
  input id3fsp_pkg::result_req_t  result_item
);
  import id3fsp_pkg::*;

  `ID3FSP_ASSERT_NEXT(a_result_held, clk, rst, result_valid && result_stall, result_valid, "result dropped while stalled")
  `ID3FSP_ASSERT_NEXT(a_result_stable, clk, rst, result_valid && result_stall, $stable(result_item), "stalled result changed")
  `ID3FSP_ASSERT_SAME(a_stall_cause, clk, rst, byte_stall, result_valid && result_stall, "byte request stalled without a held result")
  `ID3FSP_ASSERT_SAME(a_payload_fields, clk, rst, result_valid && (result_item.kind != KIND_PAYLOAD), (result_item.payload_byte == 8'd0) && !result_item.last_of_frame, "payload fields set on a non-payload result")
  `ID3FSP_ASSERT_SAME(a_error_fields, clk, rst, result_valid && (result_item.kind != KIND_ERROR), !result_item.error_code, "error code set on a non-error result")

endmodule

bind id3v2_frame_stream_parser id3fsp_checker u_id3fsp_checker (.*);

`default_nettype wire
